/* design/ttd_pkg.sv */
`default_nettype none

package ttd_pkg;

	// Grid and tree limits.
	localparam int MAX_WIDE   = 64;
	localparam int MAX_TALL   = 64;
	localparam int MAX_LEVELS = 7;

	// Fixed field widths.
	localparam int LEAF_W     = 12;
	localparam int LIMIT_W    = 6;
	localparam int WINDOW_W   = 64;
	localparam int COUNT_W    = 6;
	localparam int CFG_DATA_W = 7;
	localparam int CFG_IDX_W  = 1;

	// Geometry widths.
	localparam int WIDE_W = $clog2(MAX_WIDE + 1);
	localparam int TALL_W = $clog2(MAX_TALL + 1);
	localparam int COL_W  = (MAX_WIDE > 1) ? $clog2(MAX_WIDE) : 1;
	localparam int ROW_W  = (MAX_TALL > 1) ? $clog2(MAX_TALL) : 1;
	localparam int PROD_W = WIDE_W + TALL_W;

	// Number of stored nodes for the largest grid.
	function automatic int node_count();
		int w;
		int h;
		int total;
		bit stop;
		w = MAX_WIDE;
		h = MAX_TALL;
		total = 0;
		stop = 1'b0;
		for (int l = 0; l < MAX_LEVELS; l++) begin
			if (!stop) begin
				total = total + w * h;
				if (w * h <= 1) begin
					stop = 1'b1;
				end
				w = (w + 1) >> 1;
				h = (h + 1) >> 1;
			end
		end
		return total;
	endfunction

	localparam int NODE_DEPTH = node_count();
	localparam int ADDR_W     = (NODE_DEPTH > 1) ? $clog2(NODE_DEPTH) : 1;
	localparam int LEVEL_W    = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
	localparam int LCOUNT_W   = $clog2(MAX_LEVELS + 1);

	// Reciprocal of the grid width, scaled by two to the leaf index width.
	localparam int RECIP_SHIFT = LEAF_W;
	localparam int RECIP_W     = LEAF_W + 1;

	// Length of the clear pass, which also recomputes the geometry.
	localparam int INIT_LEN_A = (NODE_DEPTH > RECIP_W) ? NODE_DEPTH : RECIP_W;
	localparam int INIT_LEN   = (INIT_LEN_A > MAX_LEVELS) ? INIT_LEN_A : MAX_LEVELS;
	localparam int INIT_W     = $clog2(INIT_LEN);

	// Node word and walk widths.
	localparam int LOW_W     = 6;
	localparam int NODE_W    = 2 * LOW_W;
	localparam int POS_W     = 7;
	localparam int STEP_BITS = 4;
	localparam int CONS_W    = $clog2(STEP_BITS + 1);
	localparam int MAX_COUNT = (1 << COUNT_W) - 1;

	localparam logic [LOW_W-1:0]  VALUE_UNKNOWN = '1;
	localparam logic [NODE_W-1:0] CLEAR_WORD    = {VALUE_UNKNOWN, {LOW_W{1'b0}}};

	localparam logic MODE_CLEAR  = 1'b0;
	localparam logic MODE_DECODE = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_WIDE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TALL = 1'b1;

	typedef struct packed {
		logic                mode;
		logic [LEAF_W-1:0]   leaf_index;
		logic [LIMIT_W-1:0]  limit;
		logic [WINDOW_W-1:0] bit_window;
	} item_t;

	typedef struct packed {
		logic               below_limit;
		logic [COUNT_W-1:0] bits_used;
	} result_t;

	typedef struct packed {
		logic [LOW_W-1:0] value;
		logic [LOW_W-1:0] low;
	} node_t;

	typedef struct packed {
		logic [WIDE_W-1:0]                  wide;
		logic [TALL_W-1:0]                  tall;
		logic [PROD_W-1:0]                  total;
		logic [RECIP_W-1:0]                 recip;
		logic [LCOUNT_W-1:0]                levels;
		logic [MAX_LEVELS-1:0][ADDR_W-1:0]  loff;
	} geom_t;

	typedef struct packed {
		logic              done;
		logic [CONS_W-1:0] consumed;
		logic [LOW_W-1:0]  low;
		logic [LOW_W-1:0]  value;
	} step_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_DIVIDE,
		ST_SPLIT,
		ST_FETCH,
		ST_NODE
	} state_t;

endpackage

`default_nettype wire

/* design/ttd_node_ram.sv */
`default_nettype none

module ttd_node_ram #(
	parameter int DEPTH = 2,
	parameter int WIDTH = 1
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* design/ttd_geometry.sv */
`default_nettype none

module ttd_geometry (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ttd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ttd_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             step_en,
	input  logic [ttd_pkg::INIT_W-1:0]       step_idx,
	output ttd_pkg::geom_t                   geom
);

	import ttd_pkg::*;

	logic [WIDE_W-1:0]   wide_q, wide_in;
	logic [TALL_W-1:0]   tall_q, tall_in;
	logic [PROD_W-1:0]   total_q;
	logic [RECIP_W-1:0]  recip_q;
	logic [WIDE_W-1:0]   rem_q, rem_cur, rem_next;
	logic [WIDE_W:0]     trial;
	logic                qbit;
	logic [LCOUNT_W-1:0] levels_q;
	logic [MAX_LEVELS-1:0][ADDR_W-1:0] loff_q;
	logic [ADDR_W:0]     acc_q, acc_cur;
	logic                found_q, found_cur;
	logic [LEVEL_W-1:0]  lvl;
	logic [WIDE_W-1:0]   lw_c;
	logic [TALL_W-1:0]   lh_c;
	logic [PROD_W-1:0]   prod_c;
	logic                first_step;

	// Out-of-range dimensions are clamped into 1..maximum.
	always_comb begin
		if (cfg_data == '0) begin
			wide_in = WIDE_W'(1);
			tall_in = TALL_W'(1);
		end else begin
			wide_in = (int'(cfg_data) > MAX_WIDE) ? WIDE_W'(MAX_WIDE) : WIDE_W'(cfg_data);
			tall_in = (int'(cfg_data) > MAX_TALL) ? TALL_W'(MAX_TALL) : TALL_W'(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_q <= WIDE_W'(1);
			tall_q <= TALL_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDE: wide_q <= wide_in;
				REG_TALL: tall_q <= tall_in;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		total_q <= PROD_W'(wide_q) * PROD_W'(tall_q);
	end

	assign first_step = (step_idx == '0);

	// Per-level dimensions and running node offset, one level per step.
	assign lvl       = step_idx[LEVEL_W-1:0];
	assign lw_c      = ((wide_q - WIDE_W'(1)) >> lvl) + WIDE_W'(1);
	assign lh_c      = ((tall_q - TALL_W'(1)) >> lvl) + TALL_W'(1);
	assign prod_c    = PROD_W'(lw_c) * PROD_W'(lh_c);
	assign acc_cur   = first_step ? '0 : acc_q;
	assign found_cur = first_step ? 1'b0 : found_q;

	always_ff @(posedge clk) begin
		if (step_en && (step_idx < INIT_W'(MAX_LEVELS))) begin
			loff_q[lvl] <= acc_cur[ADDR_W-1:0];
			acc_q       <= acc_cur + (ADDR_W+1)'(prod_c);
			if (!found_cur && (prod_c <= PROD_W'(1))) begin
				levels_q <= LCOUNT_W'(lvl) + LCOUNT_W'(1);
				found_q  <= 1'b1;
			end else begin
				if (first_step) begin
					levels_q <= LCOUNT_W'(MAX_LEVELS);
				end
				found_q  <= found_cur;
			end
		end
	end

	// Restoring division of the scale constant by the width, one quotient bit per step.
	assign rem_cur = first_step ? '0 : rem_q;
	assign trial   = {rem_cur, first_step};
	assign qbit    = (trial >= {1'b0, wide_q});
	assign rem_next = qbit ? WIDE_W'(trial - {1'b0, wide_q}) : trial[WIDE_W-1:0];

	always_ff @(posedge clk) begin
		if (step_en && (step_idx < INIT_W'(RECIP_W))) begin
			rem_q   <= rem_next;
			recip_q <= {recip_q[RECIP_W-2:0], qbit};
		end
	end

	always_comb begin
		geom.wide   = wide_q;
		geom.tall   = tall_q;
		geom.total  = total_q;
		geom.recip  = recip_q;
		geom.levels = levels_q;
		geom.loff   = loff_q;
	end

endmodule

`default_nettype wire

/* design/ttd_node_step.sv */
`default_nettype none

module ttd_node_step (
	input  logic [ttd_pkg::LOW_W-1:0]     low,
	input  logic [ttd_pkg::LOW_W-1:0]     value,
	input  logic [ttd_pkg::LIMIT_W-1:0]   limit,
	input  logic [ttd_pkg::STEP_BITS-1:0] nibble,
	output ttd_pkg::step_t                step
);

	import ttd_pkg::*;

	logic [LOW_W-1:0]  bound;
	logic [LOW_W-1:0]  need;
	logic [CONS_W-1:0] tz;

	// The walk at a node stops at the node value or the limit, whichever is lower.
	assign bound = (value < LOW_W'(limit)) ? value : LOW_W'(limit);
	assign need  = bound - low;

	always_comb begin
		tz = CONS_W'(STEP_BITS);
		for (int i = STEP_BITS - 1; i >= 0; i--) begin
			if (nibble[i]) begin
				tz = CONS_W'(i);
			end
		end
	end

	always_comb begin
		step.done     = 1'b1;
		step.consumed = '0;
		step.low      = low;
		step.value    = value;
		if (low < bound) begin
			if (need <= LOW_W'(tz)) begin
				step.consumed = CONS_W'(need);
				step.low      = bound;
			end else if (tz != CONS_W'(STEP_BITS)) begin
				step.consumed = tz + CONS_W'(1);
				step.low      = low + LOW_W'(tz);
				step.value    = low + LOW_W'(tz);
			end else begin
				step.done     = 1'b0;
				step.consumed = CONS_W'(STEP_BITS);
				step.low      = low + LOW_W'(STEP_BITS);
			end
		end
	end

endmodule

`default_nettype wire

/* design/tag_tree_decoder_unit.sv */
`default_nettype none

// Channel   Direction  Handshake                 Word
// --------  ---------  ------------------------  ---------------------------------
// item      in         start high, busy low      mode, leaf_index, limit, bit_window
// result    out        done high for one cycle   below_limit, bits_used
// config    in         cfg_we high               cfg_index, cfg_data
//
// A decode word keeps busy high through the divide, split and fetch states and in the
// node state for each tree level in turn, staying on a node while it consumes further
// header bits. The walk is bounded by the node memory read-modify-write; the result is
// registered from the last node. Reset, a clear word and a register write while idle each
// start a clear pass that sweeps the node memory one entry per cycle with busy high; any
// register write restarts it. An out-of-range leaf answers on the next cycle with busy low.

module tag_tree_decoder_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  ttd_pkg::item_t                 item,
	output logic                           done,
	output ttd_pkg::result_t               result,
	input  logic                           cfg_we,
	input  logic [ttd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ttd_pkg::CFG_DATA_W-1:0] cfg_data
);

	import ttd_pkg::*;

	localparam int CMP_W = (LEAF_W > PROD_W) ? LEAF_W : PROD_W;
	localparam int MUL_W = LEAF_W + RECIP_W;
	localparam int YW_W  = ROW_W + WIDE_W;

	// Address of the node covering the current leaf at a given level.
	function automatic logic [ADDR_W-1:0] node_addr(
		input logic [LEVEL_W-1:0] lvl,
		input geom_t              g,
		input logic [COL_W-1:0]   x,
		input logic [ROW_W-1:0]   y
	);
		logic [WIDE_W-1:0] lw;
		logic [COL_W-1:0]  cx;
		logic [ROW_W-1:0]  cy;
		logic [ADDR_W+1:0] sum;
		lw  = ((g.wide - WIDE_W'(1)) >> lvl) + WIDE_W'(1);
		cx  = x >> lvl;
		cy  = y >> lvl;
		sum = (ADDR_W+2)'(g.loff[lvl]) + (ADDR_W+2)'(cy) * (ADDR_W+2)'(lw)
			+ (ADDR_W+2)'(cx);
		return sum[ADDR_W-1:0];
	endfunction

	state_t state_q, state_d;
	geom_t  geom;
	step_t  step;

	logic [INIT_W-1:0]   cnt_q;
	logic [LEAF_W-1:0]   leaf_q;
	logic [LIMIT_W-1:0]  limit_q;
	logic [WINDOW_W-1:0] win_q;
	logic [ROW_W-1:0]    y0_q;
	logic [COL_W-1:0]    x_q;
	logic [ROW_W-1:0]    y_q;
	logic [LEVEL_W-1:0]  level_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [LOW_W-1:0]    low_q;
	logic [LOW_W-1:0]    val_q;
	logic [POS_W-1:0]    pos_q;
	logic                first_q;
	logic                done_q;
	result_t             result_q;

	logic                accept;
	logic                out_of_range;
	logic                last_node;
	logic [MUL_W-1:0]    quot_prod;
	logic [YW_W-1:0]     yw;
	logic [LEAF_W-1:0]   rem;
	logic                rem_over;
	logic [LEVEL_W-1:0]  rd_level;
	logic [POS_W-1:0]    pos_next;
	node_t               mem_node;
	logic [LOW_W-1:0]    low_eff;
	logic [LOW_W-1:0]    val_eff;

	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [NODE_W-1:0]   ram_wdata;
	logic                ram_re;
	logic [ADDR_W-1:0]   ram_raddr;
	logic [NODE_W-1:0]   ram_rdata;

	// Geometry registers: dimensions, per-level offsets, level count and the width
	// reciprocal; the last three are rebuilt in the first cycles of every clear pass.
	ttd_geometry u_geometry (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step_en   (state_q == ST_INIT),
		.step_idx  (cnt_q),
		.geom      (geom)
	);

	// Node memory: one word per tree node holding its value (all ones while
	// unknown) and its lower bound. One write port and one registered read port.
	ttd_node_ram #(
		.DEPTH (NODE_DEPTH),
		.WIDTH (NODE_W)
	) u_node_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Bit consumption at the current node, up to four header bits per cycle.
	ttd_node_step u_node_step (
		.low    (low_eff),
		.value  (val_eff),
		.limit  (limit_q),
		.nibble (win_q[STEP_BITS-1:0]),
		.step   (step)
	);

	assign accept       = start && (state_q == ST_IDLE);
	assign out_of_range = CMP_W'(item.leaf_index) >= CMP_W'(geom.total);
	assign last_node    = (state_q == ST_NODE) && step.done && (level_q == '0);

	// Leaf row and column: the reciprocal product is low by at most one,
	// so a single compare and subtract fixes the quotient.
	assign quot_prod = MUL_W'(leaf_q) * MUL_W'(geom.recip);
	assign yw        = YW_W'(y0_q) * YW_W'(geom.wide);
	assign rem       = leaf_q - LEAF_W'(yw);
	assign rem_over  = rem >= LEAF_W'(geom.wide);

	// On entry to a node the running bound is raised to the stored bound.
	assign mem_node = node_t'(ram_rdata);
	assign low_eff  = (first_q && (mem_node.low > low_q)) ? mem_node.low : low_q;
	assign val_eff  = first_q ? mem_node.value : val_q;
	assign pos_next = pos_q + POS_W'(step.consumed);

	// The next node down is fetched in the cycle the current one is written back.
	assign rd_level  = (state_q == ST_FETCH) ? level_q : level_q - LEVEL_W'(1);
	assign ram_raddr = node_addr(rd_level, geom, x_q, y_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT: begin
				if (!cfg_we && (cnt_q == INIT_W'(INIT_LEN - 1))) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (cfg_we) begin
					state_d = ST_INIT;
				end else if (start) begin
					if (item.mode == MODE_CLEAR) begin
						state_d = ST_INIT;
					end else if (!out_of_range) begin
						state_d = ST_DIVIDE;
					end
				end
			end
			ST_DIVIDE: state_d = ST_SPLIT;
			ST_SPLIT:  state_d = ST_FETCH;
			ST_FETCH:  state_d = ST_NODE;
			ST_NODE: begin
				if (last_node) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_INIT;
		endcase
	end

	always_comb begin
		busy      = (state_q != ST_IDLE);
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = {step.value, step.low};
		ram_re    = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				ram_we    = (cnt_q < INIT_W'(NODE_DEPTH));
				ram_waddr = cnt_q[ADDR_W-1:0];
				ram_wdata = CLEAR_WORD;
			end
			ST_FETCH: begin
				ram_re = 1'b1;
			end
			ST_NODE: begin
				ram_we = step.done;
				ram_re = step.done && (level_q != '0);
			end
			ST_IDLE, ST_DIVIDE, ST_SPLIT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q != ST_INIT) || cfg_we) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + INIT_W'(1);
			end
			done_q <= (accept && ((item.mode == MODE_CLEAR) || out_of_range)) || last_node;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= '0;
		end else if (last_node) begin
			result_q.below_limit <= step.value < LOW_W'(limit_q);
			result_q.bits_used   <= (pos_next > POS_W'(MAX_COUNT)) ? COUNT_W'(MAX_COUNT)
				: pos_next[COUNT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					leaf_q  <= item.leaf_index;
					limit_q <= item.limit;
					win_q   <= item.bit_window;
				end
			end
			ST_DIVIDE: begin
				y0_q <= ROW_W'(quot_prod >> RECIP_SHIFT);
			end
			ST_SPLIT: begin
				if (rem_over) begin
					y_q <= y0_q + ROW_W'(1);
					x_q <= COL_W'(rem - LEAF_W'(geom.wide));
				end else begin
					y_q <= y0_q;
					x_q <= COL_W'(rem);
				end
				level_q <= LEVEL_W'(geom.levels - LCOUNT_W'(1));
				low_q   <= '0;
				val_q   <= VALUE_UNKNOWN;
				pos_q   <= '0;
			end
			ST_FETCH: begin
				addr_q  <= ram_raddr;
				first_q <= 1'b1;
			end
			ST_NODE: begin
				low_q   <= step.low;
				val_q   <= step.value;
				win_q   <= win_q >> step.consumed;
				pos_q   <= pos_next;
				first_q <= step.done && (level_q != '0);
				if (step.done && (level_q != '0)) begin
					addr_q  <= ram_raddr;
					level_q <= level_q - LEVEL_W'(1);
				end
			end
			ST_INIT: begin
			end
			default: begin
			end
		endcase
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef SYNTHESIS
	// A clear word answers on the next cycle with an all-zero result.
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (item.mode == MODE_CLEAR)) |=> (done && (result == '0)))
		else $error("clear word did not give a zero result");

	// Write-back and prefetch always address different tree levels.
	assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (ram_waddr != ram_raddr))
		else $error("node write-back and fetch hit the same entry");

	// Busy drops only after a clear pass or together with a decode result.
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (done || $past(state_q == ST_INIT)))
		else $error("busy dropped without a result");
`endif

endmodule

`default_nettype wire
